FILE: rtl/bbc_pkg.sv
// Package for the clipped-window box blur: sizes, FSM encoding, config indexes
// and line-store slot helpers.
// No dependencies.
package bbc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int NSLOT      = 2 * MAX_RADIUS + 1;

    localparam int W_W    = 12;               // width register
    localparam int H_W    = 13;               // height register
    localparam int R_W    = 3;                // radius register
    localparam int ROW_W  = 12;
    localparam int COL_W  = 11;
    localparam int SLOT_W = 4;
    localparam int ADDR_W = SLOT_W + COL_W;
    localparam int SUM_W  = 16;               // 225 * 255 fits
    localparam int CNT_W  = 8;                // up to 225 pixels

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WSETUP = 6'b000010,
        S_RD     = 6'b000100,
        S_ACC    = 6'b001000,
        S_DIV    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(NSLOT - 1)) ? '0 : s + 1'b1;
    endfunction

    // slot minus d, modulo NSLOT, for d below NSLOT
    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                   input logic [R_W-1:0] d);
        logic [SLOT_W:0] t;
        t = {1'b0, s} + (SLOT_W+1)'(NSLOT) - {2'b00, d};
        if (t >= (SLOT_W+1)'(NSLOT)) t = t - (SLOT_W+1)'(NSLOT);
        slot_sub = t[SLOT_W-1:0];
    endfunction

endpackage

FILE: rtl/box_blur_clipped_window.sv
// Clipped-window box blur: line store, per-result window accumulation, serial divider.
// Depends on bbc_pkg.
// Per window pixel in bounds: read from the line store (S_RD), then add (S_ACC); then a
// serial divider forms the mean and S_EMIT presents it. Input items without results are
// taken in S_IDLE; no input is taken until a burst ends. The store has a single read port.
// Reset (synchronous, active low) restores config to 2048 x 2048, radius 1, and the
// position to row 0 column 0; the line store is not cleared.
module box_blur_clipped_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_pixel_in,
    input  logic                       i_frame_start,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_blurred_pixel,
    output logic [bbc_pkg::ROW_W-1:0]  o_out_row,
    output logic [bbc_pkg::COL_W-1:0]  o_out_col,
    output logic                       o_last_of_run,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [bbc_pkg::H_W-1:0]    i_cfg_data
);
    localparam int ROW_W  = bbc_pkg::ROW_W;
    localparam int COL_W  = bbc_pkg::COL_W;
    localparam int SLOT_W = bbc_pkg::SLOT_W;
    localparam int R_W    = bbc_pkg::R_W;

    bbc_pkg::t_state r_state;

    logic [bbc_pkg::W_W-1:0] r_cfg_w;
    logic [bbc_pkg::H_W-1:0] r_cfg_h;
    logic [R_W-1:0]          r_rad;

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;
    logic              r_done;

    // burst bounds and current output position
    logic [ROW_W-1:0]  r_r, r_rhi;
    logic [SLOT_W-1:0] r_rslot;
    logic [COL_W-1:0]  r_c, r_clo, r_chi;

    // window walk
    logic [ROW_W-1:0]  r_rr, r_r1;
    logic [SLOT_W-1:0] r_wslot;
    logic [COL_W-1:0]  r_cc, r_c0, r_c1;
    logic [bbc_pkg::SUM_W-1:0] r_sum;
    logic [bbc_pkg::CNT_W-1:0] r_cnt;

    // divider
    logic [bbc_pkg::SUM_W-1:0] r_quo;
    logic [bbc_pkg::CNT_W-1:0] r_rem;
    logic [3:0]                r_step;

    logic [7:0] r_mem [bbc_pkg::NSLOT * bbc_pkg::MAX_WIDTH];
    logic [7:0] r_q;

    // effective config
    logic [bbc_pkg::W_W-1:0] eff_w;
    logic [bbc_pkg::H_W-1:0] eff_h;

    always_comb begin
        if (r_cfg_w == '0) eff_w = 12'd1;
        else if (r_cfg_w > 12'(bbc_pkg::MAX_WIDTH)) eff_w = 12'(bbc_pkg::MAX_WIDTH);
        else eff_w = r_cfg_w;
        if (r_cfg_h == '0) eff_h = 13'd1;
        else if (r_cfg_h > 13'(bbc_pkg::MAX_HEIGHT)) eff_h = 13'(bbc_pkg::MAX_HEIGHT);
        else eff_h = r_cfg_h;
    end

    // config is taken only between requests, never during a burst
    assign o_cfg_ready = (r_state == bbc_pkg::S_IDLE);
    assign o_ready     = (r_state == bbc_pkg::S_IDLE);

    // ---- input step decode ----
    logic              s_done0, s_wrap0, s_over, s_lastrow, s_lastcol, s_has_out;
    logic              s_wrap2, s_over2;
    logic [ROW_W-1:0]  s_row0;
    logic [COL_W-1:0]  s_col0, s_col1, s_clo;
    logic [SLOT_W-1:0] s_slot0, s_slot1;
    logic [ROW_W:0]    s_row1, s_row2;
    logic [COL_W:0]    s_col2;
    logic [R_W-1:0]    s_dr, s_dc;
    logic [ROW_W-1:0]  s_rlo;

    always_comb begin
        s_done0 = i_frame_start ? 1'b0 : r_done;
        s_row0  = i_frame_start ? '0 : r_row;
        s_col0  = i_frame_start ? '0 : r_col;
        s_slot0 = i_frame_start ? '0 : r_slot;
        s_wrap0 = {1'b0, s_col0} >= eff_w;
        s_row1  = {1'b0, s_row0} + (ROW_W+1)'(s_wrap0);
        s_col1  = s_wrap0 ? '0 : s_col0;
        s_slot1 = s_wrap0 ? bbc_pkg::slot_inc(s_slot0) : s_slot0;
        s_over  = s_row1 >= eff_h;
        s_lastrow = s_row1 == eff_h - 1'b1;
        s_lastcol = {1'b0, s_col1} == eff_w - 1'b1;
        s_dr = (s_row1 < (ROW_W+1)'(r_rad)) ? s_row1[R_W-1:0] : r_rad;
        s_dc = (s_col1 < COL_W'(r_rad)) ? s_col1[R_W-1:0] : r_rad;
        s_rlo = s_row1[ROW_W-1:0] - ROW_W'(s_dr);
        s_clo = s_col1 - COL_W'(s_dc);
        s_has_out = (s_lastrow || s_row1 >= (ROW_W+1)'(r_rad))
                 && (s_lastcol || s_col1 >= COL_W'(r_rad));
        s_col2  = {1'b0, s_col1} + 1'b1;
        s_wrap2 = s_col2 >= eff_w;
        s_row2  = s_row1 + 1'b1;
        s_over2 = s_row2 >= eff_h;
    end

    logic step_go, mem_we;
    assign step_go = i_valid && o_ready;
    assign mem_we  = step_go && !s_done0 && !s_over;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[{s_slot1, s_col1}] <= i_pixel_in;
        r_q <= r_mem[{r_wslot, r_cc}];
    end

    // ---- window bounds for the current output ----
    logic [R_W-1:0]   w_d;
    logic [ROW_W:0]   w_rtop;
    logic [COL_W:0]   w_ctop;
    always_comb begin
        w_d    = (r_r < ROW_W'(r_rad)) ? r_r[R_W-1:0] : r_rad;
        w_rtop = {1'b0, r_r} + (ROW_W+1)'(r_rad);
        w_ctop = {1'b0, r_c} + (COL_W+1)'(r_rad);
    end

    logic [bbc_pkg::CNT_W:0] dv_t;
    assign dv_t = {r_rem, r_quo[bbc_pkg::SUM_W-1]};

    logic out_load;
    assign out_load = (r_state == bbc_pkg::S_EMIT) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 12'(bbc_pkg::MAX_WIDTH);
            r_cfg_h <= 13'd2048;
            r_rad   <= 3'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bbc_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[bbc_pkg::W_W-1:0];
                bbc_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                bbc_pkg::CFG_RADIUS: r_rad   <= i_cfg_data[R_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
            r_done  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (out_load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;

            unique case (r_state)
                bbc_pkg::S_IDLE: begin
                    if (step_go) begin
                        if (s_done0) begin
                            r_done <= 1'b1;
                        end else if (s_over) begin
                            r_done <= 1'b1;
                            r_row  <= '0;
                            r_col  <= '0;
                            r_slot <= '0;
                        end else begin
                            r_done <= 1'b0;
                            if (s_wrap2) begin
                                r_col <= '0;
                                if (s_over2) begin
                                    r_done <= 1'b1;
                                    r_row  <= '0;
                                    r_slot <= '0;
                                end else begin
                                    r_row  <= s_row2[ROW_W-1:0];
                                    r_slot <= bbc_pkg::slot_inc(s_slot1);
                                end
                            end else begin
                                r_col  <= s_col2[COL_W-1:0];
                                r_row  <= s_row1[ROW_W-1:0];
                                r_slot <= s_slot1;
                            end
                            if (s_has_out) begin
                                r_r     <= s_rlo;
                                r_rslot <= bbc_pkg::slot_sub(s_slot1, s_dr);
                                r_rhi   <= s_lastrow ? s_row1[ROW_W-1:0] : s_rlo;
                                r_clo   <= s_clo;
                                r_chi   <= s_lastcol ? s_col1 : s_clo;
                                r_c     <= s_clo;
                                r_state <= bbc_pkg::S_WSETUP;
                            end
                        end
                    end
                end
                bbc_pkg::S_WSETUP: begin
                    r_rr    <= r_r - ROW_W'(w_d);
                    r_wslot <= bbc_pkg::slot_sub(r_rslot, w_d);
                    r_r1    <= (w_rtop >= eff_h) ? ROW_W'(eff_h - 1'b1) : w_rtop[ROW_W-1:0];
                    r_c0    <= (r_c < COL_W'(r_rad)) ? '0 : r_c - COL_W'(r_rad);
                    r_cc    <= (r_c < COL_W'(r_rad)) ? '0 : r_c - COL_W'(r_rad);
                    r_c1    <= ({1'b0, w_ctop} >= {1'b0, eff_w}) ? COL_W'(eff_w - 1'b1)
                                                                : w_ctop[COL_W-1:0];
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= bbc_pkg::S_RD;
                end
                bbc_pkg::S_RD: begin
                    r_state <= bbc_pkg::S_ACC;
                end
                bbc_pkg::S_ACC: begin
                    r_sum <= r_sum + bbc_pkg::SUM_W'(r_q);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cc == r_c1) begin
                        r_cc <= r_c0;
                        if (r_rr == r_r1) begin
                            r_quo   <= r_sum + bbc_pkg::SUM_W'(r_q);
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= bbc_pkg::S_DIV;
                        end else begin
                            r_rr    <= r_rr + 1'b1;
                            r_wslot <= bbc_pkg::slot_inc(r_wslot);
                            r_state <= bbc_pkg::S_RD;
                        end
                    end else begin
                        r_cc    <= r_cc + 1'b1;
                        r_state <= bbc_pkg::S_RD;
                    end
                end
                bbc_pkg::S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (dv_t >= {1'b0, r_cnt}) begin
                        r_rem <= bbc_pkg::CNT_W'(dv_t - {1'b0, r_cnt});
                        r_quo <= {r_quo[bbc_pkg::SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= dv_t[bbc_pkg::CNT_W-1:0];
                        r_quo <= {r_quo[bbc_pkg::SUM_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) r_state <= bbc_pkg::S_EMIT;
                end
                bbc_pkg::S_EMIT: begin
                    if (out_load) begin
                        if (r_c == r_chi) begin
                            r_c <= r_clo;
                            if (r_r == r_rhi) begin
                                r_state <= bbc_pkg::S_IDLE;
                            end else begin
                                r_r     <= r_r + 1'b1;
                                r_rslot <= bbc_pkg::slot_inc(r_rslot);
                                r_state <= bbc_pkg::S_WSETUP;
                            end
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= bbc_pkg::S_WSETUP;
                        end
                    end
                end
                default: r_state <= bbc_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_blurred_pixel <= r_quo[7:0];
            o_out_row       <= r_r;
            o_out_col       <= r_c;
            o_last_of_run   <= (r_c == r_chi) && (r_r == r_rhi);
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bbc_pkg::S_DIV |-> r_cnt != '0)
        else $error("division by an empty window");

    a_emit_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bbc_pkg::S_EMIT |-> (r_c <= r_chi) && (r_r <= r_rhi))
        else $error("output position outside burst");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(bbc_pkg::NSLOT))
        else $error("line-store slot out of range");

    a_acc_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bbc_pkg::S_ACC |=> r_state == bbc_pkg::S_RD || r_state == bbc_pkg::S_DIV)
        else $error("bad step after accumulate");

    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && (r_c == r_chi) && (r_r == r_rhi) |=> r_state == bbc_pkg::S_IDLE)
        else $error("burst did not end after last result");

endmodule
